>>> sv/wbfe_pkg.sv
// shared types, codes and tables of the breathing frame encoder
package wbfe_pkg;

   localparam int LED_COUNT_DEF = 2;
   localparam int JOB_DEPTH = 4;
   localparam int JOB_PTR_W = $clog2(JOB_DEPTH);
   localparam int JOB_CNT_W = $clog2(JOB_DEPTH + 1);

   localparam logic [1:0] OP_SET_ALL = 2'd0;
   localparam logic [1:0] OP_BREATHE = 2'd1;
   localparam logic [1:0] OP_INIT    = 2'd2;

   localparam logic [1:0] KIND_STATUS = 2'd0;
   localparam logic [1:0] KIND_DATA   = 2'd1;
   localparam logic [1:0] KIND_GAP    = 2'd2;

   localparam logic [1:0] CH_GREEN = 2'd0;
   localparam logic [1:0] CH_RED   = 2'd1;
   localparam logic [1:0] CH_BLUE  = 2'd2;

   localparam logic [1:0] CSR_DUTY_ONE  = 2'd0;
   localparam logic [1:0] CSR_DUTY_ZERO = 2'd1;
   localparam logic [1:0] CSR_INTERVAL  = 2'd2;

   localparam logic [7:0] DUTY_ONE_RST  = 8'd75;
   localparam logic [7:0] DUTY_ZERO_RST = 8'd35;
   localparam logic [15:0] INTERVAL_RST = 16'd40;

   localparam logic [5:0] SINE_MASK = 6'h3F;

   localparam logic [7:0] SINE_LUT [64] = '{
      8'd128, 8'd140, 8'd153, 8'd165, 8'd177, 8'd188, 8'd199, 8'd209,
      8'd218, 8'd226, 8'd234, 8'd240, 8'd245, 8'd250, 8'd253, 8'd254,
      8'd254, 8'd253, 8'd250, 8'd245, 8'd240, 8'd234, 8'd226, 8'd218,
      8'd209, 8'd199, 8'd188, 8'd177, 8'd165, 8'd153, 8'd140, 8'd128,
      8'd128, 8'd116, 8'd103, 8'd91,  8'd79,  8'd68,  8'd57,  8'd47,
      8'd38,  8'd30,  8'd22,  8'd16,  8'd11,  8'd6,   8'd3,   8'd2,
      8'd2,   8'd3,   8'd6,   8'd11,  8'd16,  8'd22,  8'd30,  8'd38,
      8'd47,  8'd57,  8'd68,  8'd79,  8'd91,  8'd103, 8'd116, 8'd128
   };

   typedef enum logic [1:0] {
      ACT_STATUS,
      ACT_SHOW,
      ACT_SET,
      ACT_STEP
   } act_type;

   typedef struct packed {
      logic        frame;
      logic        accepted;
      logic [23:0] color;
   } job_type;

   // c * b / 255 for c, b below 256
   function automatic logic [7:0] scale_255(input logic [7:0] c, input logic [7:0] b);
      logic [15:0] prod;
      logic [16:0] sum;
      prod = c * b;
      sum = {1'b0, prod} + 17'd1 + 17'(prod[15:8]);
      return sum[15:8];
   endfunction

endpackage

>>> sv/wbfe_front.sv
// front end: accepts items, keeps breathing state, pushes a job per accepted item
module wbfe_front
   import wbfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [1:0]           req_opcode,
   input  logic [7:0]           req_red,
   input  logic [7:0]           req_green,
   input  logic [7:0]           req_blue,
   input  logic [31:0]          req_now_ms,
   input  logic [15:0]          interval,
   input  logic [JOB_CNT_W-1:0] q_count,
   output logic                 job_push,
   output job_type              job_data
);

   logic        breathing_ff, breathing_in;
   logic [5:0]  pos_ff, pos_in;
   logic [31:0] next_ff, next_in;
   logic [23:0] shown_ff, shown_in;

   logic        s1_valid_ff;
   act_type     s1_act_ff, s1_act_in;
   logic        s1_acc_ff, s1_acc_in;
   logic [7:0]  s1_r_ff, s1_g_ff, s1_b_ff;
   logic [7:0]  s1_br_ff, s1_br_in;

   logic        accept;
   logic [31:0] due_sum;
   logic [31:0] step_time;
   logic [5:0]  cur_pos;
   logic [23:0] scaled;
   logic [JOB_CNT_W:0] used;

   assign used = {1'b0, q_count} + (JOB_CNT_W + 1)'(s1_valid_ff);
   assign req_full = used >= (JOB_CNT_W + 1)'(JOB_DEPTH);
   assign accept = req_push && !req_full;
   assign due_sum = req_now_ms + 32'(interval);

   always_comb begin
      breathing_in = breathing_ff;
      pos_in = pos_ff;
      next_in = next_ff;
      s1_act_in = ACT_STATUS;
      s1_acc_in = 1'b0;
      s1_br_in = 8'd0;
      cur_pos = breathing_ff ? pos_ff : 6'd0;
      step_time = breathing_ff ? next_ff : due_sum;
      case (req_opcode)
         OP_INIT: begin
            breathing_in = 1'b0;
            next_in = due_sum;
            s1_act_in = ACT_SHOW;
            s1_acc_in = 1'b1;
         end
         OP_SET_ALL: begin
            if (!breathing_ff) begin
               s1_act_in = ACT_SET;
               s1_acc_in = 1'b1;
            end
         end
         OP_BREATHE: begin
            breathing_in = 1'b1;
            pos_in = cur_pos;
            next_in = step_time;
            s1_acc_in = 1'b1;
            if (req_now_ms >= step_time) begin
               s1_act_in = ACT_STEP;
               s1_br_in = SINE_LUT[cur_pos & SINE_MASK];
               next_in = due_sum;
               pos_in = (cur_pos + 6'd1) & SINE_MASK;
            end
         end
         default: begin
            s1_act_in = ACT_STATUS;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         breathing_ff <= 1'b0;
         pos_ff <= 6'd0;
         next_ff <= 32'd0;
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
         if (accept) begin
            breathing_ff <= breathing_in;
            pos_ff <= pos_in;
            next_ff <= next_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_act_ff <= s1_act_in;
         s1_acc_ff <= s1_acc_in;
         s1_r_ff <= req_red;
         s1_g_ff <= req_green;
         s1_b_ff <= req_blue;
         s1_br_ff <= s1_br_in;
      end
   end

   assign scaled = {scale_255(s1_r_ff, s1_br_ff), scale_255(s1_g_ff, s1_br_ff),
                    scale_255(s1_b_ff, s1_br_ff)};

   always_comb begin
      shown_in = shown_ff;
      job_data.frame = 1'b0;
      job_data.accepted = s1_acc_ff;
      case (s1_act_ff)
         ACT_SHOW: begin
            job_data.frame = 1'b1;
         end
         ACT_SET: begin
            job_data.frame = 1'b1;
            shown_in = {s1_r_ff, s1_g_ff, s1_b_ff};
         end
         ACT_STEP: begin
            if (scaled != shown_ff) begin
               job_data.frame = 1'b1;
               shown_in = scaled;
            end
         end
         default: begin
            job_data.frame = 1'b0;
         end
      endcase
      job_data.color = shown_in;
   end

   assign job_push = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         shown_ff <= 24'd0;
      end else if (s1_valid_ff) begin
         shown_ff <= shown_in;
      end
   end

endmodule

>>> sv/wbfe_queue.sv
// short job queue between front end and frame sequencer
module wbfe_queue
   import wbfe_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  job_type              push_data,
   input  logic                 pop,
   output logic                 head_valid,
   output job_type              head_data,
   output logic [JOB_CNT_W-1:0] count
);

   job_type                entry_ff [JOB_DEPTH];
   logic [JOB_PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [JOB_CNT_W-1:0]   count_ff, count_in;
   logic                   do_pop;

   assign head_valid = count_ff != '0;
   assign head_data = entry_ff[rd_ptr_ff];
   assign count = count_ff;
   assign do_pop = pop && head_valid;

   always_comb begin
      count_in = count_ff;
      if (push && !do_pop) begin
         count_in = count_ff + JOB_CNT_W'(1);
      end else if (!push && do_pop) begin
         count_in = count_ff - JOB_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + JOB_PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + JOB_PTR_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

>>> sv/wbfe_back.sv
// back end: walks a job through its results into the output register
module wbfe_back
   import wbfe_pkg::*;
#(
   parameter int LED_COUNT = LED_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        job_valid,
   input  job_type     job_data,
   output logic        job_pop,
   input  logic [7:0]  duty_one,
   input  logic [7:0]  duty_zero,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_accepted,
   output logic [1:0]  rsp_item_kind,
   output logic [3:0]  rsp_led_index,
   output logic [1:0]  rsp_channel,
   output logic [7:0]  rsp_data_byte,
   output logic [63:0] rsp_duty_codes,
   output logic        rsp_last
);

   logic [3:0]  led_ff, led_in;
   logic [1:0]  ch_ff, ch_in;
   logic        gap_ff, gap_in;
   logic        out_valid_ff;
   logic        load;

   logic        acc_in, last_in;
   logic [1:0]  kind_in;
   logic [7:0]  byte_in;
   logic [63:0] codes_in;

   assign load = job_valid && (!out_valid_ff || rsp_pop);
   assign rsp_empty = !out_valid_ff;

   always_comb begin
      case (ch_ff)
         CH_GREEN: byte_in = job_data.color[15:8];
         CH_RED:   byte_in = job_data.color[23:16];
         default:  byte_in = job_data.color[7:0];
      endcase
      for (int b = 0; b < 8; b++) begin
         codes_in[8*b +: 8] = byte_in[b] ? duty_one : duty_zero;
      end
   end

   always_comb begin
      led_in = led_ff;
      ch_in = ch_ff;
      gap_in = gap_ff;
      job_pop = 1'b0;
      acc_in = job_data.accepted;
      kind_in = KIND_STATUS;
      last_in = 1'b1;
      if (!job_data.frame) begin
         job_pop = load;
      end else if (gap_ff) begin
         kind_in = KIND_GAP;
         job_pop = load;
         led_in = 4'd0;
         ch_in = CH_GREEN;
         gap_in = 1'b0;
      end else begin
         kind_in = KIND_DATA;
         last_in = 1'b0;
         if (ch_ff == CH_BLUE) begin
            ch_in = CH_GREEN;
            if (led_ff == 4'(LED_COUNT - 1)) begin
               gap_in = 1'b1;
            end else begin
               led_in = led_ff + 4'd1;
            end
         end else begin
            ch_in = ch_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         led_ff <= 4'd0;
         ch_ff <= CH_GREEN;
         gap_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            led_ff <= led_in;
            ch_ff <= ch_in;
            gap_ff <= gap_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_accepted <= acc_in;
         rsp_item_kind <= kind_in;
         rsp_last <= last_in;
         if (kind_in == KIND_DATA) begin
            rsp_led_index <= led_ff;
            rsp_channel <= ch_ff;
            rsp_data_byte <= byte_in;
            rsp_duty_codes <= codes_in;
         end else begin
            rsp_led_index <= 4'd0;
            rsp_channel <= CH_GREEN;
            rsp_data_byte <= 8'd0;
            rsp_duty_codes <= 64'd0;
         end
      end
   end

endmodule

>>> sv/ws2812_breathing_frame_encoder.sv
// top level of the ws2812 breathing frame encoder
//
// channel  direction  handshake            payload
// req      in         push / full          opcode, red, green, blue, now_ms
// rsp      out        empty / pop          accepted, item_kind, led_index, channel,
//                                          data_byte, duty_codes, last
// csr      in         csr_valid/csr_ready  csr_index, csr_data
//
// an accepted item is registered in the front end stage and pushed into the job queue from there
// the sequencer gives one result per cycle while rsp is popped: LED_COUNT*3+1 results per frame, one per status item
// sustained rate is set by the sequencer, which takes a new job only after the last result of the one before
// full rises when the four-entry job queue plus the item in flight fill it
// reset clears state and queue; csr_ready is always high
module ws2812_breathing_frame_encoder
   import wbfe_pkg::*;
#(
   parameter int LED_COUNT = LED_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   input  logic [31:0] req_now_ms,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic        rsp_accepted,
   output logic [1:0]  rsp_item_kind,
   output logic [3:0]  rsp_led_index,
   output logic [1:0]  rsp_channel,
   output logic [7:0]  rsp_data_byte,
   output logic [63:0] rsp_duty_codes,
   output logic        rsp_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   logic [7:0]           duty_one_ff, duty_zero_ff;
   logic [15:0]          interval_ff;
   logic                 job_push, job_pop, head_valid;
   job_type              job_in, head_job;
   logic [JOB_CNT_W-1:0] q_count;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         duty_one_ff <= DUTY_ONE_RST;
         duty_zero_ff <= DUTY_ZERO_RST;
         interval_ff <= INTERVAL_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_DUTY_ONE:  duty_one_ff <= csr_data[7:0];
            CSR_DUTY_ZERO: duty_zero_ff <= csr_data[7:0];
            CSR_INTERVAL:  interval_ff <= csr_data;
            default: begin
            end
         endcase
      end
   end

   wbfe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_push   (req_push),
      .req_full   (req_full),
      .req_opcode (req_opcode),
      .req_red    (req_red),
      .req_green  (req_green),
      .req_blue   (req_blue),
      .req_now_ms (req_now_ms),
      .interval   (interval_ff),
      .q_count    (q_count),
      .job_push   (job_push),
      .job_data   (job_in)
   );

   wbfe_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_data  (job_in),
      .pop        (job_pop),
      .head_valid (head_valid),
      .head_data  (head_job),
      .count      (q_count)
   );

   wbfe_back #(
      .LED_COUNT (LED_COUNT)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .job_valid      (head_valid),
      .job_data       (head_job),
      .job_pop        (job_pop),
      .duty_one       (duty_one_ff),
      .duty_zero      (duty_zero_ff),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_accepted   (rsp_accepted),
      .rsp_item_kind  (rsp_item_kind),
      .rsp_led_index  (rsp_led_index),
      .rsp_channel    (rsp_channel),
      .rsp_data_byte  (rsp_data_byte),
      .rsp_duty_codes (rsp_duty_codes),
      .rsp_last       (rsp_last)
   );

endmodule
